### src/srlsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlsm_pkg
// Shared widths and constants of the stereo rms level smoother.
// ----------------------------------------------------------------------------
package srlsm_pkg;

	localparam int SAMPLE_W   = 16;     // signed q1.15 sample
	localparam int SQ_W       = 29;     // square of a halved sample, at most 2^28
	localparam int MEAN_W     = 29;     // block mean square, at most 2^28
	localparam int RMS_W      = 15;     // block rms, at most 16384
	localparam int LEVEL_W    = 16;     // smoothed level register
	localparam int OUT_W      = 15;     // output field width
	localparam int COEF_W     = 16;     // q0.16 coefficients
	localparam int PROD_W     = 32;     // coefficient products
	localparam int SQRT_STEPS = 15;     // two radicand bits per step

	localparam int MAX_BLOCK_PAIRS_DEF = 1024;

	localparam logic [COEF_W-1:0] COEF_KEEP  = 16'd60948;   // 0.93
	localparam logic [COEF_W-1:0] COEF_NEW   = 16'd4588;    // 0.07
	localparam logic [PROD_W-1:0] ROUND_HALF = 32'd32768;

endpackage

`default_nettype wire

### src/srlsm_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlsm_lane
// One channel lane: halves a q1.15 sample and registers its square.
// ----------------------------------------------------------------------------
module srlsm_lane
	import srlsm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       load,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic         [SQ_W-1:0]         square_s1
);

	logic signed [SAMPLE_W-2:0]   halved;
	logic signed [2*SAMPLE_W-3:0] prod;

	// arithmetic shift right by one, floor toward minus infinity
	assign halved = sample[SAMPLE_W-1:1];
	assign prod   = halved * halved;

	always_ff @(posedge clk) begin
		if (load) begin
			square_s1 <= prod[SQ_W-1:0];
		end
	end

endmodule

`default_nettype wire

### src/srlsm_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlsm_divider
// Restoring divider, one quotient bit per cycle, for the block mean square.
// ----------------------------------------------------------------------------
module srlsm_divider
	import srlsm_pkg::*;
#(
	parameter int DIVIDEND_W = 40,
	parameter int DIVISOR_W  = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [MEAN_W-1:0]          quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_sub;
	logic                  ge;

	assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge      = rem_sh >= {1'b0, dvr_q};
	assign rem_sub = rem_sh - {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[MEAN_W-1:0];

endmodule

`default_nettype wire

### src/srlsm_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlsm_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module srlsm_sqrt
	import srlsm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MEAN_W-1:0] radicand,
	output logic                   done,
	output logic [RMS_W-1:0]       root
);

	localparam int VAL_W = 2 * SQRT_STEPS;
	localparam int REM_W = RMS_W + 3;
	localparam int CNT_W = $clog2(SQRT_STEPS + 1);

	logic [VAL_W-1:0] val_q;
	logic [REM_W-1:0] rem_q;
	logic [RMS_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	// remainder never exceeds twice the partial root, so its top bits are zero
	assign rem_sh = {rem_q[REM_W-3:0], val_q[VAL_W-1:VAL_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SQRT_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= VAL_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[VAL_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RMS_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

### src/stereo_rms_level_smoother_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_rms_level_smoother_top
// Block rms of stereo q1.15 pairs with an exponentially smoothed level.
// ----------------------------------------------------------------------------
// A pair that does not close a block is taken in ST_IDLE, where the two
// channel lanes square both halved samples, and its squares are merged into
// the running sum in ST_ACCUM. A closing pair (tlast, or the
// MAX_BLOCK_PAIRS-th pair) goes on after take and merge through the serial
// divider, one quotient bit per sum bit, and the square root, with a handover
// after each of the two, then the multiplies in ST_MUL_KEEP and ST_MUL_NEW,
// the level update and the load of the output register; s_axis_tready is low.
// One result leaves per closed block; it waits in the output register while
// the next pairs are taken, and a further closing pair stalls only once the
// new result is ready and the previous one has not yet been taken.
// ----------------------------------------------------------------------------
module stereo_rms_level_smoother_top
	import srlsm_pkg::*;
#(
	parameter int MAX_BLOCK_PAIRS = MAX_BLOCK_PAIRS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // left_sample [15:0], right_sample [31:16]
	input  wire logic        s_axis_tlast,   // last_in_block
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // block_rms [14:0], smoothed_level [29:15], zero
);

	localparam int CNT_W = $clog2(MAX_BLOCK_PAIRS + 1);
	localparam int SUM_W = CNT_W + SQ_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIVIDE,
		ST_ROOT,
		ST_MUL_KEEP,
		ST_MUL_NEW,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     count_q;
	logic                 last_s1;
	logic [LEVEL_W-1:0]   level_q;
	logic [RMS_W-1:0]     rms_q;
	logic [PROD_W-1:0]    prod_keep_q;
	logic [PROD_W-1:0]    prod_new_q;
	logic                 out_valid_q;
	logic [31:0]          out_data_q;

	logic                 accept;
	logic [SQ_W-1:0]      square_l_s1;
	logic [SQ_W-1:0]      square_r_s1;
	logic [SUM_W-1:0]     sum_next;
	logic [CNT_W-1:0]     count_next;
	logic                 close;
	logic                 div_start;
	logic                 div_done;
	logic [MEAN_W-1:0]    mean;
	logic                 root_done;
	logic [RMS_W-1:0]     root;
	logic [PROD_W:0]      level_sum;
	logic                 emit;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	srlsm_lane u_lane_left (
		.clk       (clk),
		.load      (accept),
		.sample    (s_axis_tdata[SAMPLE_W-1:0]),
		.square_s1 (square_l_s1)
	);

	srlsm_lane u_lane_right (
		.clk       (clk),
		.load      (accept),
		.sample    (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.square_s1 (square_r_s1)
	);

	// merge of both lanes into the running block sum
	assign sum_next   = sum_q + SUM_W'(square_l_s1) + SUM_W'(square_r_s1);
	assign count_next = count_q + CNT_W'(1);
	assign close      = last_s1 || (count_next == CNT_W'(MAX_BLOCK_PAIRS));
	assign div_start  = (state_q == ST_ACCUM) && close;

	srlsm_divider #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W + 1)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  ({count_next, 1'b0}),
		.done     (div_done),
		.quotient (mean)
	);

	srlsm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_done),
		.radicand (mean),
		.done     (root_done),
		.root     (root)
	);

	assign level_sum = (PROD_W+1)'(prod_keep_q) + (PROD_W+1)'(prod_new_q)
		+ (PROD_W+1)'(ROUND_HALF);

	// output register free, or emptied at this very edge
	assign emit = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					if (close) begin
						sum_q   <= '0;
						count_q <= '0;
						state_q <= ST_DIVIDE;
					end else begin
						sum_q   <= sum_next;
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_MUL_KEEP;
					end
				end
				ST_MUL_KEEP: begin
					state_q <= ST_MUL_NEW;
				end
				ST_MUL_NEW: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					level_q <= level_sum[LEVEL_W+15:16];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= s_axis_tlast;
		end
		if (root_done) begin
			rms_q <= root;
		end
		if (state_q == ST_MUL_KEEP) begin
			prod_keep_q <= {16'd0, COEF_KEEP} * {16'd0, level_q};
		end
		if (state_q == ST_MUL_NEW) begin
			prod_new_q <= {16'd0, COEF_NEW} * {17'd0, rms_q};
		end
		if (emit) begin
			out_data_q <= {2'b00, level_q[OUT_W-1:0], rms_q[OUT_W-1:0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(MAX_BLOCK_PAIRS))
		else $error("pair count reached the block bound without closing");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> sum_q == '0)
		else $error("square sum not cleared at block start");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVIDE)
		else $error("divider finished outside the divide state");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result raised without a block close");

endmodule

`default_nettype wire
